// ===== src/gf4alu_pkg.sv =====
// ----------------------------------------------------------------------------
// gf4alu_pkg
// Types, command codes and mod-251 reduction helpers for the GF(251^4) unit.
// ----------------------------------------------------------------------------
package gf4alu_pkg;

	// base field prime and derived widths
	localparam int unsigned PRIME  = 251;
	localparam int unsigned COEF_W = 8;
	localparam int unsigned PROD_W = 2 * COEF_W;
	// widest unreduced sum is ten raw products; ACC_W leaves room for twenty
	localparam int unsigned ACC_W  = $clog2(20 * 255 * 255 + 1);
	localparam int unsigned LIN_W  = 10;
	localparam int unsigned MID_W  = 15;
	localparam int unsigned NCOEF  = 4;

	typedef logic [COEF_W-1:0] coef_t;
	typedef logic [PROD_W-1:0] prod_t;
	typedef logic [ACC_W-1:0]  acc_t;
	typedef logic [LIN_W-1:0]  lin_t;
	typedef logic [MID_W-1:0]  mid_t;

	// command codes
	typedef enum logic [2:0] {
		CMD_MUL   = 3'd0,
		CMD_ADD   = 3'd1,
		CMD_SUB   = 3'd2,
		CMD_SCALE = 3'd3,
		CMD_CMP   = 3'd4
	} cmd_t;

	// request payload
	typedef struct packed {
		logic [2:0] cmd;
		coef_t      a_coef0;
		coef_t      a_coef1;
		coef_t      a_coef2;
		coef_t      a_coef3;
		coef_t      b_coef0;
		coef_t      b_coef1;
		coef_t      b_coef2;
		coef_t      b_coef3;
		coef_t      scalar;
	} req_t;

	// response payload
	typedef struct packed {
		coef_t r_coef0;
		coef_t r_coef1;
		coef_t r_coef2;
		coef_t r_coef3;
		logic  equal;
	} rsp_t;

	// 8x8 unsigned product
	function automatic prod_t mul8(input coef_t x, input coef_t y);
		return PROD_W'(x) * PROD_W'(y);
	endfunction

	// 2^8 = 5 mod 251: fold the high byte back in (acc -> below 20731)
	function automatic mid_t fold_acc(input acc_t x);
		mid_t hi;
		hi = MID_W'(x[ACC_W-1:COEF_W]);
		return (hi << 2) + hi + MID_W'(x[COEF_W-1:0]);
	endfunction

	// second fold (-> below 891)
	function automatic lin_t fold_mid(input mid_t x);
		lin_t hi;
		hi = LIN_W'(x[MID_W-1:COEF_W]);
		return (hi << 2) + hi + LIN_W'(x[COEF_W-1:0]);
	endfunction

	// last fold and one conditional subtract (-> 0..250)
	function automatic coef_t fold_final(input lin_t x);
		logic [COEF_W:0] hi;
		logic [COEF_W:0] s;
		hi = (COEF_W+1)'(x[LIN_W-1:COEF_W]);
		s  = (hi << 2) + hi + (COEF_W+1)'(x[COEF_W-1:0]);
		if (s >= (COEF_W+1)'(PRIME)) begin
			s = s - (COEF_W+1)'(PRIME);
		end
		return s[COEF_W-1:0];
	endfunction

endpackage

// ===== src/gf4_stream_if.sv =====
// ----------------------------------------------------------------------------
// gf4_stream_if
// Valid/ready stream channel carrying one payload struct per transfer.
// ----------------------------------------------------------------------------
interface gf4_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== src/gf251_quartic_ext_alu_core.sv =====
// ----------------------------------------------------------------------------
// gf251_quartic_ext_alu_core
// GF(251^4) tower-field ALU: multiply, add, subtract, scale and compare.
// ----------------------------------------------------------------------------
// Four-stage pipeline that takes one request per cycle unless the output
// stalls; each result passes stages 1 to 4 in order. Stage 1 forms the
// sixteen 8x8 coefficient products, the four scalar products and the
// add/subtract sums and the compare flag; stage 2 adds the products into unreduced tower
// coefficients; stages 3 and 4 fold them mod 251 (2^8 = 5) to 0..250. Stage
// 4 is the output register. A stall on the response side freezes all stages
// together, so nothing is dropped or repeated; req.ready is low only while a
// result waits in stage 4 and the response side is not ready.
module gf251_quartic_ext_alu_core
	import gf4alu_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	gf4_stream_if.sink         req,
	gf4_stream_if.source       rsp
);

	logic en;

	// stage 1 registers
	logic                       v_s1;
	logic [2:0]                 cmd_s1;
	logic                       eq_s1;
	prod_t [NCOEF-1:0][NCOEF-1:0] prod_s1;
	prod_t [NCOEF-1:0]          sprod_s1;
	lin_t  [NCOEF-1:0]          lin_s1;

	// stage 2 registers
	logic                       v_s2;
	logic                       eq_s2;
	acc_t  [NCOEF-1:0]          acc_s2;

	// stage 3 registers
	logic                       v_s3;
	logic                       eq_s3;
	lin_t  [NCOEF-1:0]          part_s3;

	// stage 4 (output) registers
	logic                       v_s4;
	rsp_t                       rsp_s4;

	coef_t [NCOEF-1:0]          a_v;
	coef_t [NCOEF-1:0]          b_v;
	acc_t  [NCOEF-1:0]          acc_d;
	coef_t [NCOEF-1:0]          r_d;

	// whole pipeline advances unless a result is held at the output
	assign en        = !v_s4 || rsp.ready;
	assign req.ready = en;
	assign rsp.valid = v_s4;
	assign rsp.data  = rsp_s4;

	assign a_v = {req.data.a_coef3, req.data.a_coef2, req.data.a_coef1, req.data.a_coef0};
	assign b_v = {req.data.b_coef3, req.data.b_coef2, req.data.b_coef1, req.data.b_coef0};

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: products, linear sums, compare
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= req.data.cmd;
			eq_s1  <= (req.data.cmd == CMD_CMP) && (a_v == b_v);
			for (int i = 0; i < NCOEF; i++) begin
				for (int j = 0; j < NCOEF; j++) begin
					prod_s1[i][j] <= mul8(a_v[i], b_v[j]);
				end
				sprod_s1[i] <= mul8(req.data.scalar, b_v[i]);
				if (req.data.cmd == CMD_ADD) begin
					lin_s1[i] <= LIN_W'(a_v[i]) + LIN_W'(b_v[i]);
				end else begin
					// a + 2p - b stays positive for any 8-bit pattern
					lin_s1[i] <= LIN_W'(a_v[i]) + LIN_W'(2 * PRIME) - LIN_W'(b_v[i]);
				end
			end
		end
	end

	// stage 2 select: unreduced tower coefficients per command
	always_comb begin
		acc_d = '0;
		case (cmd_s1)
			CMD_MUL: begin
				// r0 = c0 + l0 + 2 l1
				acc_d[0] = ACC_W'(prod_s1[0][0]) + (ACC_W'(prod_s1[1][1]) << 1)
					+ ACC_W'(prod_s1[2][2]) + (ACC_W'(prod_s1[3][3]) << 1)
					+ (ACC_W'(prod_s1[2][3]) << 1) + (ACC_W'(prod_s1[3][2]) << 1);
				// r1 = c1 + l0 + l1
				acc_d[1] = ACC_W'(prod_s1[0][1]) + ACC_W'(prod_s1[1][0])
					+ ACC_W'(prod_s1[2][2]) + (ACC_W'(prod_s1[3][3]) << 1)
					+ ACC_W'(prod_s1[2][3]) + ACC_W'(prod_s1[3][2]);
				// r2 = m0 + n0
				acc_d[2] = ACC_W'(prod_s1[0][2]) + (ACC_W'(prod_s1[1][3]) << 1)
					+ ACC_W'(prod_s1[2][0]) + (ACC_W'(prod_s1[3][1]) << 1);
				// r3 = m1 + n1
				acc_d[3] = ACC_W'(prod_s1[0][3]) + ACC_W'(prod_s1[1][2])
					+ ACC_W'(prod_s1[2][1]) + ACC_W'(prod_s1[3][0]);
			end
			CMD_ADD, CMD_SUB: begin
				for (int i = 0; i < NCOEF; i++) begin
					acc_d[i] = ACC_W'(lin_s1[i]);
				end
			end
			CMD_SCALE: begin
				for (int i = 0; i < NCOEF; i++) begin
					acc_d[i] = ACC_W'(sprod_s1[i]);
				end
			end
			default: begin
				acc_d = '0;
			end
		endcase
	end

	// stage 2 register
	always_ff @(posedge clk) begin
		if (en) begin
			acc_s2 <= acc_d;
			eq_s2  <= eq_s1;
		end
	end

	// stage 3: two folds of 2^8 = 5
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NCOEF; i++) begin
				part_s3[i] <= fold_mid(fold_acc(acc_s2[i]));
			end
			eq_s3 <= eq_s2;
		end
	end

	// stage 4: final fold and conditional subtract
	always_comb begin
		for (int i = 0; i < NCOEF; i++) begin
			r_d[i] = fold_final(part_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_s4.r_coef0 <= r_d[0];
			rsp_s4.r_coef1 <= r_d[1];
			rsp_s4.r_coef2 <= r_d[2];
			rsp_s4.r_coef3 <= r_d[3];
			rsp_s4.equal   <= eq_s3;
		end
	end

`ifndef SYNTH
	// every delivered coefficient is fully reduced
	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.data.r_coef0 < COEF_W'(PRIME)) && (rsp.data.r_coef1 < COEF_W'(PRIME))
			&& (rsp.data.r_coef2 < COEF_W'(PRIME)) && (rsp.data.r_coef3 < COEF_W'(PRIME)))
		else $error("unreduced result coefficient");

	// a result with the equal flag set carries zero coefficients
	a_cmp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.equal |-> (rsp.data.r_coef0 == '0) && (rsp.data.r_coef1 == '0)
			&& (rsp.data.r_coef2 == '0) && (rsp.data.r_coef3 == '0))
		else $error("compare result with nonzero coefficients");

	// input side stalls only because of a held output
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready == (!rsp.valid || rsp.ready))
		else $error("request ready does not follow output stall");

	// an accepted request is registered into stage 1 when the output is ready
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && rsp.ready |=> v_s1)
		else $error("accepted request lost in stage 1");
`endif

endmodule

// ===== tb/gf251_quartic_ext_alu_core_tb.sv =====
// ----------------------------------------------------------------------------
// gf251_quartic_ext_alu_core_tb
// Self-checking bench for the GF(251^4) ALU. Every accepted request is run
// through a local tower-field calculator, and the result is queued in order.
// Each response transfer is then checked field by field against the oldest
// queued result. A directed set covers the zero and top coefficients, the
// unreduced encodings and the undefined command codes. After it comes a long
// random stream, with random gaps on both channels and one long response
// stall that backs the pipeline up into the request side.
// ----------------------------------------------------------------------------
module gf251_quartic_ext_alu_core_tb;
	import gf4alu_pkg::*;

	// expected results and the GF(251^4) arithmetic that produces them
	class gf4_ledger;
		rsp_t        pending_results[$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
		endfunction

		// (u0 + u1 X)(v0 + v1 X) with X^2 = 2, reduced mod 251
		function void quad_mul(input int unsigned u0, u1, v0, v1,
			output int unsigned w0, w1);
			w0 = (u0 * v0 + 2 * u1 * v1) % PRIME;
			w1 = (u0 * v1 + u1 * v0) % PRIME;
		endfunction

		function rsp_t field_result(req_t q);
			int unsigned a[4];
			int unsigned b[4];
			int unsigned r[4];
			int unsigned c0, c1, l0, l1, m0, m1, n0, n1;
			rsp_t        res;
			a = '{q.a_coef0, q.a_coef1, q.a_coef2, q.a_coef3};
			b = '{q.b_coef0, q.b_coef1, q.b_coef2, q.b_coef3};
			r = '{0, 0, 0, 0};
			res.equal = 1'b0;
			case (q.cmd)
				CMD_MUL: begin
					// A0 B0 + (X+1) A1 B1, and A0 B1 + A1 B0 on Y
					quad_mul(a[0], a[1], b[0], b[1], c0, c1);
					quad_mul(a[2], a[3], b[2], b[3], l0, l1);
					quad_mul(a[0], a[1], b[2], b[3], m0, m1);
					quad_mul(a[2], a[3], b[0], b[1], n0, n1);
					r[0] = (c0 + l0 + 2 * l1) % PRIME;
					r[1] = (c1 + l0 + l1) % PRIME;
					r[2] = (m0 + n0) % PRIME;
					r[3] = (m1 + n1) % PRIME;
				end
				CMD_ADD: begin
					foreach (r[i]) r[i] = (a[i] + b[i]) % PRIME;
				end
				CMD_SUB: begin
					foreach (r[i]) r[i] = (a[i] % PRIME + PRIME - b[i] % PRIME) % PRIME;
				end
				CMD_SCALE: begin
					foreach (r[i]) r[i] = (q.scalar * b[i]) % PRIME;
				end
				CMD_CMP: begin
					// raw bit patterns, so unreduced codes never match their residue
					res.equal = (a == b);
				end
				default: begin
				end
			endcase
			res.r_coef0 = coef_t'(r[0]);
			res.r_coef1 = coef_t'(r[1]);
			res.r_coef2 = coef_t'(r[2]);
			res.r_coef3 = coef_t'(r[3]);
			return res;
		endfunction

		function void note_request(req_t q);
			pending_results.push_back(field_result(q));
		endfunction

		function void check_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (pending_results.size() == 0) begin
				$error("response transfer with no request outstanding");
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			check_field("r_coef0", want.r_coef0, got.r_coef0);
			check_field("r_coef1", want.r_coef1, got.r_coef1);
			check_field("r_coef2", want.r_coef2, got.r_coef2);
			check_field("r_coef3", want.r_coef3, got.r_coef3);
			check_field("equal", want.equal, got.equal);
		endfunction
	endclass

	localparam int unsigned RANDOM_ITEMS = 850;
	localparam int unsigned LONG_STALL   = 400;
	localparam int unsigned STALL_AT     = 150;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned sent = 0;
	bit          send_burst = 1'b0;
	gf4_ledger   ledger = new();

	gf4_stream_if #(.data_t(req_t)) req_ch ();
	gf4_stream_if #(.data_t(rsp_t)) rsp_ch ();

	gf251_quartic_ext_alu_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// clock
	always #5 clk = ~clk;

	// request with the same value in every coefficient of a, of b
	function automatic req_t uniform_req(logic [2:0] c, coef_t av, coef_t bv, coef_t sv);
		req_t q;
		q.cmd     = c;
		q.a_coef0 = av;
		q.a_coef1 = av;
		q.a_coef2 = av;
		q.a_coef3 = av;
		q.b_coef0 = bv;
		q.b_coef1 = bv;
		q.b_coef2 = bv;
		q.b_coef3 = bv;
		q.scalar  = sv;
		return q;
	endfunction

	// mostly reduced coefficients, now and then an unreduced code
	function automatic coef_t rand_coef();
		if ($urandom_range(0, 7) == 0) begin
			return coef_t'($urandom_range(PRIME, 255));
		end
		return coef_t'($urandom_range(0, PRIME - 1));
	endfunction

	function automatic req_t rand_request();
		req_t q;
		q = uniform_req(CMD_MUL, rand_coef(), rand_coef(), rand_coef());
		if ($urandom_range(0, 11) == 0) begin
			q.cmd = 3'($urandom_range(CMD_CMP + 1, 7));
		end else begin
			q.cmd = 3'($urandom_range(CMD_MUL, CMD_CMP));
		end
		q.a_coef0 = rand_coef();
		q.a_coef1 = rand_coef();
		q.a_coef2 = rand_coef();
		q.a_coef3 = rand_coef();
		q.b_coef0 = rand_coef();
		q.b_coef1 = rand_coef();
		q.b_coef2 = rand_coef();
		q.b_coef3 = rand_coef();
		// compares need matching operands often enough to see the flag set
		if (q.cmd == CMD_CMP && $urandom_range(0, 1) == 0) begin
			q.b_coef0 = q.a_coef0;
			q.b_coef1 = q.a_coef1;
			q.b_coef2 = q.a_coef2;
			q.b_coef3 = q.a_coef3;
			if ($urandom_range(0, 3) == 0) begin
				q.b_coef2 = q.a_coef2 ^ coef_t'(1 << $urandom_range(0, COEF_W - 1));
			end
		end
		return q;
	endfunction

	// one request transfer, after a random gap
	task automatic send_request(input req_t item);
		int unsigned gap;
		if (sent % 50 == 0) begin
			send_burst = ($urandom_range(0, 2) == 0);
		end
		gap = send_burst ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= item;
		do @(posedge clk); while (!req_ch.ready);
		ledger.note_request(item);
		sent++;
	endtask

	// stimulus and end of run
	initial begin : stimulus
		req_t item;
		arst_n = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every command code, defined or not, on all-zero and all-top operands
		for (int c = 0; c < 8; c++) send_request(uniform_req(3'(c), 8'd0, 8'd0, 8'd0));
		for (int c = 0; c < 8; c++) send_request(uniform_req(3'(c), 8'd250, 8'd250, 8'd250));
		// unreduced codes in every defined command
		for (int c = CMD_MUL; c <= CMD_CMP; c++) begin
			send_request(uniform_req(3'(c), 8'd255, 8'd255, 8'd255));
		end
		send_request(uniform_req(CMD_SUB, 8'd255, 8'd0, 8'd0));
		send_request(uniform_req(CMD_SUB, 8'd0, 8'd255, 8'd0));
		// zero against its unreduced twin must not compare equal
		send_request(uniform_req(CMD_CMP, 8'd0, 8'd251, 8'd0));
		item = uniform_req(CMD_CMP, 8'd17, 8'd17, 8'd0);
		item.b_coef3 = 8'd18;
		send_request(item);
		// Y * Y = X + 1
		item = uniform_req(CMD_MUL, 8'd0, 8'd0, 8'd0);
		item.a_coef2 = 8'd1;
		item.b_coef2 = 8'd1;
		send_request(item);

		repeat (RANDOM_ITEMS) send_request(rand_request());
		req_ch.valid <= 1'b0;

		// drain, then give the pipeline time to show any extra transfer
		while (ledger.pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (ledger.mismatches == 0 && ledger.pending_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// response side: random stalls, bursts, and one long hold-off
	initial begin : result_sink
		int unsigned stall;
		int unsigned taken;
		bit          burst;
		taken = 0;
		burst = 1'b0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken % 40 == 0) begin
				burst = ($urandom_range(0, 3) == 0);
			end
			stall = burst ? 0 : $urandom_range(0, 15);
			if (taken == STALL_AT) begin
				stall = LONG_STALL;
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			ledger.check_result(rsp_ch.data);
			taken++;
		end
	end

	// watchdog
	initial begin : watchdog
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
